[src/frot_pkg.sv]
// Shared constants, codes and types of the quarter-turn frame rotator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package frot_pkg;

    localparam int PIXEL_W    = 24;
    localparam int COORD_W    = 8;
    localparam int DIM_W      = 9;
    localparam int DIM_MAX    = 2**DIM_W - 1;
    localparam int ROT_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_ROTATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
    localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
    localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
    localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

    localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

    typedef struct packed {
        logic [ROT_W-1:0] rotation;
        logic [DIM_W-1:0] image_height;
        logic [DIM_W-1:0] image_width;
    } frot_cfg_t;

    typedef struct packed {
        logic               is_rd;
        logic [PIXEL_W-1:0] pixel;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } frot_entry_t;

endpackage

`default_nettype wire

[src/frot_if.sv]
// Stream interfaces of the frame rotator: command items in, pixel items out.
// Depends on frot_pkg for field widths.
`default_nettype none

interface frot_in_if;
    import frot_pkg::*;

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [PIXEL_W-1:0] pixel_in;

    modport source (output valid, output cmd, output pixel_in, input ready);
    modport sink   (input valid, input cmd, input pixel_in, output ready);
endinterface

interface frot_out_if;
    import frot_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_out;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               last_of_frame;

    modport source (output valid, output pixel_out, output out_row, output out_col,
                    output last_of_frame, input ready);
    modport sink   (input valid, input pixel_out, input out_row, input out_col,
                    input last_of_frame, output ready);
endinterface

`default_nettype wire

[src/frame_rotate_90_steps_core.sv]
// Frame store that rotates an image by quarter turns; holds the config registers.
// Depends on frot_pkg, frot_if, frot_front, frot_queue and frot_back.
//
// Write items store one pixel in raster order of the input image; read items
// return the next pixel of the rotated image with its row, column and a last-of-frame
// mark. The block takes one item per clock as long as results are taken; a read result
// passes through the queue stage and the registered read of the single-port frame
// memory before it leaves. The memory is not cleared: load a frame before reading it.
// Change configuration only while the block is idle.
`default_nettype none

module frame_rotate_90_steps_core #(
    parameter int MAX_WIDTH  = frot_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = frot_pkg::DEF_MAX_HEIGHT
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire  [frot_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  wire  [frot_pkg::CFG_DATA_W-1:0]  cfg_data,
    frot_in_if.sink                          req,
    frot_out_if.source                       rsp
);
    import frot_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    frot_cfg_t cfg_reg, cfg_next;

    logic              push, full, pop, empty;
    frot_entry_t       f_entry, q_entry;
    logic [ADDR_W-1:0] f_addr, q_addr;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                REG_ROTATION: cfg_next.rotation     = cfg_data[ROT_W-1:0];
                REG_HEIGHT:   cfg_next.image_height = cfg_data[DIM_W-1:0];
                REG_WIDTH:    cfg_next.image_width  = cfg_data[DIM_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rotation     <= ROT_0;
            cfg_reg.image_height <= DIM_RESET;
            cfg_reg.image_width  <= DIM_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    frot_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cfg   (cfg_reg),
        .full  (full),
        .push  (push),
        .entry (f_entry),
        .addr  (f_addr)
    );

    frot_queue #(
        .ADDR_W (ADDR_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .entry_in  (f_entry),
        .addr_in   (f_addr),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .entry_out (q_entry),
        .addr_out  (q_addr)
    );

    frot_back #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (empty),
        .entry (q_entry),
        .addr  (q_addr),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

[src/frot_front.sv]
// Front end: accepts command items, keeps write and read positions and maps each
// read to its source address. Depends on frot_pkg and frot_if.
`default_nettype none

module frot_front #(
    parameter int MAX_WIDTH  = frot_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = frot_pkg::DEF_MAX_HEIGHT,
    parameter int ADDR_W     = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    frot_in_if.sink             req,
    input  frot_pkg::frot_cfg_t cfg,
    input  wire                 full,
    output logic                push,
    output frot_pkg::frot_entry_t entry,
    output logic [ADDR_W-1:0]   addr
);
    import frot_pkg::*;

    localparam int HCAP = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
    localparam int WCAP = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;

    logic [DIM_W-1:0]   h, w, out_h, out_w;
    logic [2*DIM_W-1:0] total, prod, src;
    logic [ADDR_W-1:0]  wp;
    logic [ADDR_W:0]    wp_inc;
    logic [DIM_W-1:0]   rr, rc, rc_inc, rr_inc, sr, sc;
    logic               accept, is_rd, last;

    logic [ADDR_W-1:0] wpos_reg, wpos_next;
    logic [DIM_W-1:0]  rrow_reg, rrow_next;
    logic [DIM_W-1:0]  rcol_reg, rcol_next;

    assign h = (cfg.image_height == '0) ? DIM_W'(1) :
               (cfg.image_height > DIM_W'(HCAP)) ? DIM_W'(HCAP) : cfg.image_height;
    assign w = (cfg.image_width == '0) ? DIM_W'(1) :
               (cfg.image_width > DIM_W'(WCAP)) ? DIM_W'(WCAP) : cfg.image_width;
    assign total = h * w;

    assign out_h = cfg.rotation[0] ? w : h;
    assign out_w = cfg.rotation[0] ? h : w;

    assign req.ready = !full;
    assign accept    = req.valid && req.ready;
    assign is_rd     = (req.cmd == CMD_READ);
    assign push      = accept;

    // write position
    assign wp     = (wpos_reg >= total) ? '0 : wpos_reg;
    assign wp_inc = {1'b0, wp} + 1'b1;

    // read position, restarted when outside the rotated frame
    always_comb
    begin
        if ((rrow_reg >= out_h) || (rcol_reg >= out_w))
        begin
            rr = '0;
            rc = '0;
        end
        else
        begin
            rr = rrow_reg;
            rc = rcol_reg;
        end
    end

    always_comb
    begin
        case (cfg.rotation)
            ROT_90:
            begin
                sr = h - 1'b1 - rc;
                sc = rr;
            end
            ROT_180:
            begin
                sr = h - 1'b1 - rr;
                sc = w - 1'b1 - rc;
            end
            ROT_270:
            begin
                sr = rc;
                sc = w - 1'b1 - rr;
            end
            default:
            begin
                sr = rr;
                sc = rc;
            end
        endcase
    end

    assign prod = sr * w;
    assign src  = prod + {{DIM_W{1'b0}}, sc};

    assign rc_inc = rc + 1'b1;
    assign rr_inc = rr + 1'b1;
    assign last   = (rc_inc >= out_w) && (rr_inc >= out_h);

    always_comb
    begin
        wpos_next = wpos_reg;
        rrow_next = rrow_reg;
        rcol_next = rcol_reg;
        if (accept && !is_rd)
        begin
            wpos_next = (wp_inc >= total) ? '0 : wp_inc[ADDR_W-1:0];
        end
        if (accept && is_rd)
        begin
            if (rc_inc >= out_w)
            begin
                rcol_next = '0;
                rrow_next = (rr_inc >= out_h) ? '0 : rr_inc;
            end
            else
            begin
                rcol_next = rc_inc;
                rrow_next = rr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg <= '0;
            rrow_reg <= '0;
            rcol_reg <= '0;
        end
        else
        begin
            wpos_reg <= wpos_next;
            rrow_reg <= rrow_next;
            rcol_reg <= rcol_next;
        end
    end

    assign entry.is_rd = is_rd;
    assign entry.pixel = req.pixel_in;
    assign entry.row   = rr[COORD_W-1:0];
    assign entry.col   = rc[COORD_W-1:0];
    assign entry.last  = last;
    assign addr        = is_rd ? ADDR_W'(src) : wp;

endmodule

`default_nettype wire

[src/frot_queue.sv]
// Short queue between front and back end of the frame rotator.
// Depends on frot_pkg.
`default_nettype none

module frot_queue #(
    parameter int ADDR_W = 16
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    input  frot_pkg::frot_entry_t entry_in,
    input  wire  [ADDR_W-1:0]     addr_in,
    output logic                  full,
    input  wire                   pop,
    output logic                  empty,
    output frot_pkg::frot_entry_t entry_out,
    output logic [ADDR_W-1:0]     addr_out
);
    import frot_pkg::*;

    frot_entry_t       entry_mem [QUEUE_DEPTH];
    logic [ADDR_W-1:0] addr_mem  [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign entry_out = entry_mem[rd_ptr_reg];
    assign addr_out  = addr_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= entry_in;
            addr_mem[wr_ptr_reg]  <= addr_in;
        end
    end

endmodule

`default_nettype wire

[src/frot_back.sv]
// Back end: frame memory and result register of the frame rotator.
// Depends on frot_pkg and frot_if.
`default_nettype none

module frot_back #(
    parameter int ADDR_W = 16,
    parameter int DEPTH  = 65536
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   empty,
    input  frot_pkg::frot_entry_t entry,
    input  wire  [ADDR_W-1:0]     addr,
    output logic                  pop,
    frot_out_if.source            rsp
);
    import frot_pkg::*;

    logic [PIXEL_W-1:0] mem [DEPTH];

    logic               out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0] rdata_reg;
    logic [COORD_W-1:0] row_reg, col_reg;
    logic               last_reg;

    assign pop = !empty && (!entry.is_rd || !out_valid_reg || rsp.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop && entry.is_rd)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (entry.is_rd)
            begin
                rdata_reg <= mem[addr];
                row_reg   <= entry.row;
                col_reg   <= entry.col;
                last_reg  <= entry.last;
            end
            else
            begin
                mem[addr] <= entry.pixel;
            end
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.pixel_out     = rdata_reg;
    assign rsp.out_row       = row_reg;
    assign rsp.out_col       = col_reg;
    assign rsp.last_of_frame = last_reg;

endmodule

`default_nettype wire
